/* hdl/lfpd_pkg.sv */
// shared types, constants and functions of the line follower controller
`timescale 1ns / 1ps
package lfpd_pkg;

    typedef enum logic [1:0] {
        PH_FOLLOW = 2'd0,
        PH_BRAKE  = 2'd1,
        PH_TURN   = 2'd2,
        PH_SEARCH = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_CORNER_R    = 3'd1,
        EV_CORNER_L    = 3'd2,
        EV_LOST        = 3'd3,
        EV_FOUND       = 3'd4,
        EV_SEARCH      = 3'd5,
        EV_OVERSHOOT   = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        CFG_ENABLE     = 3'd0,
        CFG_INVERT     = 3'd1,
        CFG_BASE_SPEED = 3'd2,
        CFG_TURN_SPEED = 3'd3,
        CFG_PROP_GAIN  = 3'd4,
        CFG_DERIV_GAIN = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMA,
        ST_DIV,
        ST_DISP,
        ST_MUL_P,
        ST_MUL_D,
        ST_ROUND,
        ST_SAT,
        ST_MOD,
        ST_REM,
        ST_SLOW,
        ST_FAST,
        ST_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       ema;
        logic       div_ema;
        logic       mul_p;
        logic       mul_d;
        logic       rnd;
        logic       sat;
        logic       mod_q;
        logic       mod_rem;
        logic       div_slow;
        logic       div_fast;
        logic       commit;
    } lfpd_cmd_t;

    typedef struct packed {
        logic   enable;
        phase_t phase;
        logic   lost;
        logic   lit_zero;
        logic   out_free;
    } lfpd_status_t;

    localparam logic [15:0] RST_BASE_SPEED = 16'd7680;
    localparam logic [15:0] RST_TURN_SPEED = 16'd15360;
    localparam logic [15:0] RST_PROP_GAIN  = 16'd1536;
    localparam logic [15:0] RST_DERIV_GAIN = 16'd512;
    localparam logic [15:0] BRAKE_SPEED    = 16'd256;
    localparam logic [31:0] BRAKE_MS       = 32'd200;
    localparam logic [31:0] TURN_MIN_MS    = 32'd500;
    localparam logic [31:0] TURN_MAX_MS    = 32'd3000;
    localparam logic [31:0] SEARCH_MAX_MS  = 32'd4000;
    localparam logic [31:0] COOL_TURN_MS   = 32'd800;
    localparam logic [31:0] COOL_FOUND_MS  = 32'd500;
    localparam logic [10:0] SWEEP_PERIOD   = 11'd800;
    localparam logic [9:0]  SWEEP_HALF     = 10'd400;
    localparam logic [7:0]  CENTER_RESTORE = 8'd20;
    localparam logic [4:0]  ALL_LIT        = 5'b11111;
    localparam logic [4:0]  CENTER_ONLY    = 5'b00100;
    localparam logic [4:0]  POS_FRAC       = 5'd13;
    localparam logic [19:0] DIV5_MUL       = 20'd838861;
    localparam int          DIV5_SHIFT     = 22;
    // floor(x / 25) for x below 2^27
    localparam logic [27:0] DIV25_MUL      = 28'd171798692;
    localparam int          DIV25_SHIFT    = 32;
    localparam logic signed [15:0] STEER_TH  = 16'sd128;
    localparam logic signed [15:0] OVER_TH   = 16'sd256;
    localparam logic signed [15:0] FOUND_CORR = 16'sd1024;

    // raw line position in q3.13, rounded half away from zero
    function automatic logic signed [15:0] raw_pos(input logic [4:0] s);
        logic [2:0]        lit;
        logic [2:0]        pos;
        logic [2:0]        neg;
        logic [1:0]        mag;
        logic [15:0]       r;
        lit = {2'b0, s[0]} + {2'b0, s[1]} + {2'b0, s[2]} + {2'b0, s[3]} + {2'b0, s[4]};
        pos = {1'b0, s[4], 1'b0} + {2'b0, s[3]};
        neg = {1'b0, s[0], 1'b0} + {2'b0, s[1]};
        mag = (pos >= neg) ? 2'(pos - neg) : 2'(neg - pos);
        r = 16'd0;
        case (mag)
            2'd1:
            begin
                case (lit)
                    3'd1: r = 16'd8192;
                    3'd2: r = 16'd4096;
                    3'd3: r = 16'd2731;
                    3'd4: r = 16'd2048;
                    3'd5: r = 16'd1638;
                    default: r = 16'd0;
                endcase
            end
            2'd2:
            begin
                case (lit)
                    3'd1: r = 16'd16384;
                    3'd2: r = 16'd8192;
                    3'd3: r = 16'd5461;
                    3'd4: r = 16'd4096;
                    3'd5: r = 16'd3277;
                    default: r = 16'd0;
                endcase
            end
            2'd3:
            begin
                case (lit)
                    3'd1: r = 16'd24576;
                    3'd2: r = 16'd12288;
                    3'd3: r = 16'd8192;
                    3'd4: r = 16'd6144;
                    3'd5: r = 16'd4915;
                    default: r = 16'd0;
                endcase
            end
            default: r = 16'd0;
        endcase
        return (neg > pos) ? -$signed(r) : $signed(r);
    endfunction

    // halve toward zero
    function automatic logic signed [15:0] halve(input logic signed [15:0] v);
        logic signed [15:0] t;
        t = v + {15'd0, v[15]};
        return t >>> 1;
    endfunction

    function automatic logic signed [1:0] sign_of(input logic signed [15:0] c);
        if (c > STEER_TH)
            return 2'sb01;
        else if (c < -STEER_TH)
            return 2'sb11;
        else
            return 2'sb00;
    endfunction

    function automatic logic [15:0] clamp_speed(input logic signed [17:0] v);
        if (v < 0)
            return 16'd0;
        else if (v > 18'sd65535)
            return 16'hffff;
        else
            return v[15:0];
    endfunction

endpackage

/* hdl/lfpd_if.sv */
// valid/ready channel interfaces for sensor words and result words
`timescale 1ns / 1ps
interface lfpd_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  sensor_bits;
    logic [31:0] time_ms;

    modport source (output valid, output sensor_bits, output time_ms, input ready);
    modport sink (input valid, input sensor_bits, input time_ms, output ready);
endinterface

interface lfpd_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        left_speed;
    logic [15:0]        right_speed;
    logic               left_forward;
    logic               right_forward;
    logic [1:0]         phase_now;
    logic signed [1:0]  steer_action;
    logic [2:0]         event_code;

    modport source (output valid, output left_speed, output right_speed,
                    output left_forward, output right_forward, output phase_now,
                    output steer_action, output event_code, input ready);
    modport sink (input valid, input left_speed, input right_speed,
                  input left_forward, input right_forward, input phase_now,
                  input steer_action, input event_code, output ready);
endinterface

/* hdl/lfpd_ctrl.sv */
// sequencing state machine of the line follower controller
`timescale 1ns / 1ps
module lfpd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lfpd_pkg::lfpd_status_t st,
    output lfpd_pkg::lfpd_cmd_t    cmd
);
    import lfpd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && st.enable)
                    state_next = ST_EMA;
            end
            ST_EMA:   state_next = ST_DIV;
            ST_DIV:   state_next = ST_DISP;
            ST_DISP:
            begin
                case (st.phase)
                    PH_FOLLOW: state_next = st.lost ? ST_COMMIT : ST_MUL_P;
                    PH_SEARCH: state_next = st.lit_zero ? ST_MOD : ST_COMMIT;
                    default:   state_next = ST_COMMIT;
                endcase
            end
            ST_MUL_P: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_ROUND;
            ST_ROUND: state_next = ST_SAT;
            ST_SAT:   state_next = ST_COMMIT;
            ST_MOD:   state_next = ST_REM;
            ST_REM:   state_next = ST_SLOW;
            ST_SLOW:  state_next = ST_FAST;
            ST_FAST:  state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (st.out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EMA:    cmd.ema      = 1'b1;
            ST_DIV:    cmd.div_ema  = 1'b1;
            ST_MUL_P:  cmd.mul_p    = 1'b1;
            ST_MUL_D:  cmd.mul_d    = 1'b1;
            ST_ROUND:  cmd.rnd      = 1'b1;
            ST_SAT:    cmd.sat      = 1'b1;
            ST_MOD:    cmd.mod_q    = 1'b1;
            ST_REM:    cmd.mod_rem  = 1'b1;
            ST_SLOW:   cmd.div_slow = 1'b1;
            ST_FAST:   cmd.div_fast = 1'b1;
            ST_COMMIT: cmd.commit   = st.out_free;
            default:   cmd          = '0;
        endcase
    end

endmodule

/* hdl/lfpd_datapath.sv */
// state, arithmetic and result register of the line follower controller
`timescale 1ns / 1ps
module lfpd_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic [4:0]             sensor_bits,
    input  logic [31:0]            time_ms,
    input  lfpd_pkg::lfpd_cmd_t     cmd,
    output lfpd_pkg::lfpd_status_t  st,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            left_speed,
    output logic [15:0]            right_speed,
    output logic                   left_forward,
    output logic                   right_forward,
    output logic [1:0]             phase_now,
    output logic signed [1:0]      steer_action,
    output logic [2:0]             event_code
);
    import lfpd_pkg::*;

    // configuration
    logic        enable_reg;
    logic        invert_reg;
    logic [15:0] base_reg;
    logic [15:0] turn_reg;
    logic [15:0] pgain_reg;
    logic [15:0] dgain_reg;

    // controller state
    phase_t             phase_reg;
    logic signed [15:0] sm_reg;
    logic signed [15:0] pp_reg;
    logic [4:0]         psens_reg;
    logic [7:0]         cent_reg;
    logic [7:0]         off_reg;
    logic [1:0]         bt_reg;
    logic signed [15:0] last_reg;
    logic [3:0]         decay_reg;
    logic signed [1:0]  steer_reg;
    logic signed [1:0]  cdir_reg;
    logic [31:0]        start_reg;
    logic [31:0]        cool_reg;
    logic [15:0]        held_l_reg;
    logic [15:0]        held_r_reg;

    // per word work registers
    logic [4:0]         s_reg;
    logic [4:0]         prev_reg;
    logic [31:0]        now_reg;
    logic [31:0]        el_reg;
    logic [18:0]        xmag_reg;
    logic               xneg_reg;
    logic signed [34:0] acc_reg;
    logic [34:0]        rmag_reg;
    logic               rneg_reg;
    logic signed [15:0] corr_raw_reg;
    logic [22:0]        mq_reg;
    logic [9:0]         mod_reg;
    logic [15:0]        slow_reg;
    logic [15:0]        fast_reg;

    // result register
    logic               out_valid_reg;
    logic [15:0]        out_l_reg;
    logic [15:0]        out_r_reg;
    logic               out_lf_reg;
    logic               out_rf_reg;
    phase_t             out_ph_reg;
    logic signed [1:0]  out_st_reg;
    event_t             out_ev_reg;

    // combinational helpers
    logic               lit_zero;
    logic               center_only;
    logic [7:0]         cent_upd;
    logic signed [15:0] raw;
    logic signed [18:0] x_sum;
    logic [18:0]        div_in;
    logic [38:0]        div_prod;
    logic [16:0]        div_q;
    logic signed [16:0] pp_diff;
    logic [4:0]         shamt;
    logic [34:0]        shifted;
    logic [54:0]        mod_prod;
    logic [31:0]        mod_sub;

    // commit next values
    phase_t             phase_next;
    logic signed [15:0] sm_next;
    logic signed [15:0] pp_next;
    logic [7:0]         cent_next;
    logic [1:0]         bt_next;
    logic signed [15:0] last_next;
    logic [3:0]         decay_next;
    logic signed [1:0]  steer_next;
    logic signed [1:0]  cdir_next;
    logic [31:0]        start_next;
    logic [31:0]        cool_next;
    logic [15:0]        held_l_next;
    logic [15:0]        held_r_next;
    logic               lf_next;
    logic               rf_next;
    event_t             ev_next;
    logic signed [15:0] corr;

    assign lit_zero    = (s_reg == 5'd0);
    assign center_only = (s_reg == CENTER_ONLY);
    assign cent_upd    = center_only ? ((cent_reg == 8'hff) ? cent_reg : cent_reg + 8'd1)
                                     : 8'd0;
    assign raw         = raw_pos(s_reg);
    assign x_sum       = ({{3{sm_reg[15]}}, sm_reg} <<< 1)
                       + {{3{raw[15]}}, raw} + ({{3{raw[15]}}, raw} <<< 1);

    always_comb
    begin
        if (cmd.div_slow)
            div_in = {1'b0, base_reg, 2'b00} + 19'd2;
        else if (cmd.div_fast)
            div_in = {1'b0, base_reg, 2'b00} + {2'b00, base_reg, 1'b0} + 19'd2;
        else
            div_in = xmag_reg + 19'd2;
    end

    assign div_prod = div_in * DIV5_MUL;
    assign div_q    = div_prod[DIV5_SHIFT +: 17];
    assign pp_diff  = {sm_reg[15], sm_reg} - {pp_reg[15], pp_reg};
    assign shamt    = POS_FRAC + {1'b0, decay_reg};
    assign shifted  = rmag_reg >> shamt;
    // elapsed / 800 as (elapsed / 32) / 25, then the remainder
    assign mod_prod = el_reg[31:5] * DIV25_MUL;
    assign mod_sub  = el_reg - 32'(mq_reg * SWEEP_PERIOD);

    assign st.enable   = enable_reg;
    assign st.phase    = phase_reg;
    assign st.lost     = !(now_reg < cool_reg) && lit_zero && (prev_reg != ALL_LIT);
    assign st.lit_zero = lit_zero;
    assign st.out_free = !out_valid_reg || out_ready;

    // outcome of one tick
    always_comb
    begin
        phase_next  = phase_reg;
        sm_next     = sm_reg;
        pp_next     = pp_reg;
        cent_next   = cent_reg;
        bt_next     = bt_reg;
        last_next   = last_reg;
        decay_next  = decay_reg;
        steer_next  = steer_reg;
        cdir_next   = cdir_reg;
        start_next  = start_reg;
        cool_next   = cool_reg;
        held_l_next = held_l_reg;
        held_r_next = held_r_reg;
        lf_next     = 1'b1;
        rf_next     = 1'b1;
        ev_next     = EV_NONE;
        corr        = corr_raw_reg;
        case (phase_reg)
            PH_FOLLOW:
            begin
                if (st.lost)
                begin
                    start_next = now_reg;
                    if (!prev_reg[0] && (prev_reg[4:3] != 2'b00))
                    begin
                        cdir_next  = 2'sb01;
                        phase_next = PH_BRAKE;
                        ev_next    = EV_CORNER_R;
                    end
                    else if (!prev_reg[4] && (prev_reg[1:0] != 2'b00))
                    begin
                        cdir_next  = 2'sb11;
                        phase_next = PH_BRAKE;
                        ev_next    = EV_CORNER_L;
                    end
                    else
                    begin
                        phase_next = PH_SEARCH;
                        ev_next    = EV_LOST;
                    end
                end
                else
                begin
                    if (bt_reg != 2'd0)
                    begin
                        corr    = -halve(last_reg);
                        bt_next = bt_reg - 2'd1;
                        if (bt_reg == 2'd1)
                            corr = 16'sd0;
                    end
                    else if ((last_reg > OVER_TH && corr_raw_reg < -OVER_TH) ||
                             (last_reg < -OVER_TH && corr_raw_reg > OVER_TH))
                    begin
                        if (decay_reg != 4'hf)
                            decay_next = decay_reg + 4'd1;
                        corr    = halve(corr_raw_reg);
                        ev_next = EV_OVERSHOOT;
                    end
                    else if (s_reg[2] && steer_reg != 2'sb00)
                    begin
                        bt_next   = 2'd2;
                        corr      = -halve(last_reg);
                        cent_next = 8'd0;
                    end
                    else if (off_reg < 8'd2 && cent_reg < 8'd2)
                    begin
                        corr = 16'sd0;
                    end
                    last_next   = corr;
                    steer_next  = sign_of(corr);
                    held_l_next = clamp_speed($signed({2'b00, base_reg})
                                              + {{2{corr[15]}}, corr});
                    held_r_next = clamp_speed($signed({2'b00, base_reg})
                                              - {{2{corr[15]}}, corr});
                end
            end
            PH_BRAKE:
            begin
                held_l_next = BRAKE_SPEED;
                held_r_next = BRAKE_SPEED;
                lf_next     = 1'b0;
                rf_next     = 1'b0;
                steer_next  = 2'sb00;
                if (el_reg >= BRAKE_MS)
                begin
                    phase_next = PH_TURN;
                    start_next = now_reg;
                    pp_next    = 16'sd0;
                    sm_next    = 16'sd0;
                end
            end
            PH_TURN:
            begin
                held_l_next = turn_reg;
                held_r_next = turn_reg;
                if (cdir_reg == 2'sb01)
                begin
                    rf_next    = 1'b0;
                    steer_next = 2'sb01;
                end
                else
                begin
                    lf_next    = 1'b0;
                    steer_next = 2'sb11;
                end
                pp_next = sm_reg;
                if (!lit_zero && el_reg > TURN_MIN_MS)
                begin
                    lf_next    = 1'b1;
                    rf_next    = 1'b1;
                    phase_next = PH_FOLLOW;
                    cool_next  = now_reg + COOL_TURN_MS;
                    ev_next    = EV_FOUND;
                end
                else if (lit_zero && el_reg > TURN_MAX_MS)
                begin
                    lf_next    = 1'b1;
                    rf_next    = 1'b1;
                    phase_next = PH_SEARCH;
                    start_next = now_reg;
                    steer_next = cdir_reg;
                    ev_next    = EV_SEARCH;
                end
            end
            default:
            begin
                if (!lit_zero)
                begin
                    phase_next = PH_FOLLOW;
                    cool_next  = now_reg + COOL_FOUND_MS;
                    bt_next    = 2'd2;
                    last_next  = (steer_reg == 2'sb01) ? FOUND_CORR : -FOUND_CORR;
                    steer_next = 2'sb00;
                    ev_next    = EV_FOUND;
                end
                else
                begin
                    if (mod_reg < SWEEP_HALF)
                    begin
                        held_l_next = slow_reg;
                        held_r_next = fast_reg;
                        steer_next  = 2'sb01;
                    end
                    else
                    begin
                        held_l_next = fast_reg;
                        held_r_next = slow_reg;
                        steer_next  = 2'sb11;
                    end
                    if (el_reg > SEARCH_MAX_MS)
                    begin
                        held_l_next = 16'd0;
                        held_r_next = 16'd0;
                        steer_next  = 2'sb00;
                    end
                end
            end
        endcase
    end

    // configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            invert_reg <= 1'b0;
            base_reg   <= RST_BASE_SPEED;
            turn_reg   <= RST_TURN_SPEED;
            pgain_reg  <= RST_PROP_GAIN;
            dgain_reg  <= RST_DERIV_GAIN;
            phase_reg  <= PH_FOLLOW;
            sm_reg     <= 16'sd0;
            pp_reg     <= 16'sd0;
            psens_reg  <= 5'd0;
            cent_reg   <= 8'd0;
            off_reg    <= 8'd0;
            bt_reg     <= 2'd0;
            last_reg   <= 16'sd0;
            decay_reg  <= 4'd0;
            steer_reg  <= 2'sb00;
            cdir_reg   <= 2'sb00;
            start_reg  <= 32'd0;
            cool_reg   <= 32'd0;
            held_l_reg <= 16'd0;
            held_r_reg <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:
                    begin
                        enable_reg <= cfg_data[0];
                        if (!cfg_data[0])
                            phase_reg <= PH_FOLLOW;
                    end
                    CFG_INVERT:     invert_reg <= cfg_data[0];
                    CFG_BASE_SPEED: base_reg   <= cfg_data;
                    CFG_TURN_SPEED: turn_reg   <= cfg_data;
                    CFG_PROP_GAIN:  pgain_reg  <= cfg_data;
                    CFG_DERIV_GAIN: dgain_reg  <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.ema)
            begin
                psens_reg <= s_reg;
                cent_reg  <= cent_upd;
                off_reg   <= center_only ? 8'd0
                             : ((off_reg == 8'hff) ? off_reg : off_reg + 8'd1);
                if (cent_upd >= CENTER_RESTORE)
                    decay_reg <= 4'd0;
            end
            if (cmd.div_ema && !lit_zero)
                sm_reg <= xneg_reg ? -$signed(div_q[15:0]) : $signed(div_q[15:0]);
            if (cmd.mul_d)
                pp_reg <= sm_reg;
            if (cmd.commit)
            begin
                phase_reg  <= phase_next;
                sm_reg     <= sm_next;
                pp_reg     <= pp_next;
                cent_reg   <= cent_next;
                bt_reg     <= bt_next;
                last_reg   <= last_next;
                decay_reg  <= decay_next;
                steer_reg  <= steer_next;
                cdir_reg   <= cdir_next;
                start_reg  <= start_next;
                cool_reg   <= cool_next;
                held_l_reg <= held_l_next;
                held_r_reg <= held_r_next;
            end
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg   <= sensor_bits ^ {5{invert_reg}};
            now_reg <= time_ms;
        end
        if (cmd.ema)
        begin
            prev_reg <= psens_reg;
            el_reg   <= now_reg - start_reg;
            xneg_reg <= x_sum[18];
            xmag_reg <= x_sum[18] ? 19'(-x_sum) : 19'(x_sum);
        end
        if (cmd.mul_p)
            acc_reg <= 35'($signed({1'b0, pgain_reg}) * sm_reg);
        if (cmd.mul_d)
            acc_reg <= acc_reg + 35'($signed({1'b0, dgain_reg}) * pp_diff);
        if (cmd.rnd)
        begin
            rneg_reg <= acc_reg[34];
            rmag_reg <= (acc_reg[34] ? 35'(-acc_reg) : 35'(acc_reg))
                        + (35'd1 << (shamt - 5'd1));
        end
        if (cmd.sat)
        begin
            if (rneg_reg)
                corr_raw_reg <= (shifted > 35'd32768) ? -16'sd32768
                                                      : -$signed(shifted[15:0]);
            else
                corr_raw_reg <= (shifted > 35'd32767) ? 16'sd32767
                                                      : $signed(shifted[15:0]);
        end
        if (cmd.mod_q)
            mq_reg <= mod_prod[DIV25_SHIFT +: 23];
        if (cmd.mod_rem)
            mod_reg <= mod_sub[9:0];
        if (cmd.div_slow)
            slow_reg <= div_q[15:0];
        if (cmd.div_fast)
            fast_reg <= div_q[16] ? 16'hffff : div_q[15:0];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_l_reg  <= held_l_next;
            out_r_reg  <= held_r_next;
            out_lf_reg <= lf_next;
            out_rf_reg <= rf_next;
            out_ph_reg <= phase_next;
            out_st_reg <= steer_next;
            out_ev_reg <= ev_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_speed    = out_l_reg;
    assign right_speed   = out_r_reg;
    assign left_forward  = out_lf_reg;
    assign right_forward = out_rf_reg;
    assign phase_now     = out_ph_reg;
    assign steer_action  = out_st_reg;
    assign event_code    = out_ev_reg;

endmodule

/* hdl/line_follow_pd_mode_controller_top.sv */
// top level of the five-sensor pd line follower with mode sequencing
// One sensor word per control tick gives one result word while enabled and none while
// disabled. In the brake, turn, lost and found cases an accepted word passes the EMA,
// divide and dispatch states and then the commit state into the result register.
// Follow adds two multiplies and a rounding shift for the pd term, and a sweep search
// adds a reciprocal multiply and a subtract for the elapsed-time modulo of 800, then
// the two sweep speeds. A disabled word is taken in the idle state with no result. The
// next word is accepted once the previous one has reached the result register; a result
// that is not taken while a new one is ready holds the block for as long as it waits.
`timescale 1ns / 1ps
module line_follow_pd_mode_controller_top (
    input  logic         clk,
    input  logic         rst_n,
    lfpd_in_if.sink      sensor,
    lfpd_out_if.source   result,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import lfpd_pkg::*;

    lfpd_cmd_t    cmd;
    lfpd_status_t st;
    logic         in_ready;

    assign sensor.ready = in_ready;

    lfpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sensor.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    lfpd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sensor_bits   (sensor.sensor_bits),
        .time_ms       (sensor.time_ms),
        .cmd           (cmd),
        .st            (st),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .left_speed    (result.left_speed),
        .right_speed   (result.right_speed),
        .left_forward  (result.left_forward),
        .right_forward (result.right_forward),
        .phase_now     (result.phase_now),
        .steer_action  (result.steer_action),
        .event_code    (result.event_code)
    );

endmodule

/* hdl/lfpd_checker.sv */
// port-level checks of the line follower controller and their binding
`timescale 1ns / 1ps
module lfpd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [15:0]       left_speed,
    input logic [15:0]       right_speed,
    input logic              left_forward,
    input logic              right_forward,
    input logic [1:0]        phase_now,
    input logic signed [1:0] steer_action,
    input logic [2:0]        event_code
);
    import lfpd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_speed)
                                    && $stable(event_code))
        else $error("result word dropped while stalled");

    a_brake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_now == PH_BRAKE && event_code == EV_NONE
        |-> left_speed == BRAKE_SPEED && right_speed == BRAKE_SPEED
            && !left_forward && !right_forward)
        else $error("brake tick with wrong wheel command");

    a_overshoot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == EV_OVERSHOOT |-> phase_now == PH_FOLLOW)
        else $error("overshoot outside follow");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == EV_FOUND
        |-> phase_now == PH_FOLLOW && left_forward && right_forward)
        else $error("line found without return to follow");

    a_steer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> steer_action != 2'sb10)
        else $error("steering code out of range");

endmodule

bind line_follow_pd_mode_controller_top lfpd_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .left_speed    (result.left_speed),
    .right_speed   (result.right_speed),
    .left_forward  (result.left_forward),
    .right_forward (result.right_forward),
    .phase_now     (result.phase_now),
    .steer_action  (result.steer_action),
    .event_code    (result.event_code)
);

/* tb/tb_lfpd_if.sv */
// interfaces of the testbench copy are the rtl ones; this file holds the expected result word type
`timescale 1ns / 1ps
package tb_lfpd_pkg;
    import lfpd_pkg::*;

    typedef struct {
        logic [15:0]       left_speed;
        logic [15:0]       right_speed;
        logic              left_forward;
        logic              right_forward;
        logic [1:0]        phase_now;
        logic signed [1:0] steer_action;
        logic [2:0]        event_code;
    } drive_word_t;
endpackage

/* tb/tb_line_follow_pd_mode_controller_top.sv */
// testbench of the line follower controller: directed table plus random ticks against a predictor
`timescale 1ns / 1ps
module tb_line_follow_pd_mode_controller_top;
    import lfpd_pkg::*;
    import tb_lfpd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    lfpd_in_if  sensor ();
    lfpd_out_if result ();

    line_follow_pd_mode_controller_top DUT (
        .clk(clk), .rst_n(rst_n), .sensor(sensor.sink), .result(result.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // controller settings and state of the predictor
    logic        m_enable, m_invert;
    logic [15:0] m_base, m_turn, m_kp, m_kd;
    phase_t      m_phase;
    longint      m_smooth, m_prev_pos, m_last_corr;
    logic [4:0]  m_prev_s;
    int          m_ctr_ticks, m_off_ticks, m_brake_ticks, m_decay;
    int          m_steer, m_corner;
    logic [31:0] m_phase_start, m_cool_until;
    logic [15:0] m_held_l, m_held_r;

    drive_word_t expected_words[$];
    int          idle_pct, stall_pct;
    longint      cycle_count;
    bit          failed;
    logic [31:0] clock_ms;

    function automatic longint round_div(longint num, longint den);
        longint q;
        q = ((num < 0 ? -num : num) + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint round_shr(longint v, int n);
        longint q;
        q = ((v < 0 ? -v : v) + (longint'(1) << (n - 1))) >>> n;
        return v < 0 ? -q : q;
    endfunction

    function automatic int steer_of(longint c);
        return c > 128 ? 1 : (c < -128 ? -1 : 0);
    endfunction

    function automatic logic [15:0] wheel_clamp(longint v);
        return v < 0 ? 16'd0 : (v > 65535 ? 16'hffff : 16'(v));
    endfunction

    task automatic reset_model();
        m_enable = 0; m_invert = 0;
        m_base = RST_BASE_SPEED; m_turn = RST_TURN_SPEED;
        m_kp = RST_PROP_GAIN; m_kd = RST_DERIV_GAIN;
        m_phase = PH_FOLLOW; m_smooth = 0; m_prev_pos = 0; m_last_corr = 0;
        m_prev_s = 0; m_ctr_ticks = 0; m_off_ticks = 0; m_brake_ticks = 0; m_decay = 0;
        m_steer = 0; m_corner = 0; m_phase_start = 0; m_cool_until = 0;
        m_held_l = 0; m_held_r = 0;
    endtask

    task automatic predict_tick(input logic [4:0] bits_in, input logic [31:0] now);
        logic [4:0]  s, prev;
        int          lit, num, ev;
        logic        lf, rf, speed_set;
        logic [15:0] ls, rs;
        logic [31:0] el, slow, fast;
        longint      raw, acc, corr;
        drive_word_t w;
        if (!m_enable)
            return;
        lf = 1; rf = 1; ev = EV_NONE; speed_set = 0;
        prev = m_prev_s;
        s = m_invert ? ~bits_in : bits_in;
        m_prev_s = s;
        lit = s[0] + s[1] + s[2] + s[3] + s[4];
        if (lit > 0)
        begin
            num = -2 * s[0] - s[1] + s[3] + 2 * s[4];
            raw = round_div(longint'(num) * 8192, lit);
            m_smooth = round_div(2 * m_smooth + 3 * raw, 5);
        end
        if (s == CENTER_ONLY)
        begin
            if (m_ctr_ticks < 255) m_ctr_ticks++;
            m_off_ticks = 0;
        end
        else
        begin
            if (m_off_ticks < 255) m_off_ticks++;
            m_ctr_ticks = 0;
        end
        if (m_ctr_ticks >= 20 && m_decay > 0) m_decay = 0;
        ls = m_held_l; rs = m_held_r;
        el = now - m_phase_start;
        case (m_phase)
            PH_FOLLOW:
            begin
                if (!(now < m_cool_until) && lit == 0 && prev != ALL_LIT)
                begin
                    m_phase_start = now;
                    if (!prev[0] && (prev & 5'd24) != 0)
                    begin
                        m_corner = 1; m_phase = PH_BRAKE; ev = EV_CORNER_R;
                    end
                    else if (!prev[4] && (prev & 5'd3) != 0)
                    begin
                        m_corner = -1; m_phase = PH_BRAKE; ev = EV_CORNER_L;
                    end
                    else
                    begin
                        m_phase = PH_SEARCH; ev = EV_LOST;
                    end
                end
                else
                begin
                    acc = longint'(m_kp) * m_smooth + longint'(m_kd) * (m_smooth - m_prev_pos);
                    m_prev_pos = m_smooth;
                    acc = round_shr(acc, 13 + m_decay);
                    if (acc > 32767) acc = 32767;
                    if (acc < -32768) acc = -32768;
                    corr = acc;
                    if (m_brake_ticks > 0)
                    begin
                        corr = -(m_last_corr / 2);
                        m_brake_ticks--;
                        if (m_brake_ticks == 0)
                        begin
                            corr = 0; m_steer = 0;
                        end
                    end
                    else if ((m_last_corr > 256 && corr < -256) ||
                             (m_last_corr < -256 && corr > 256))
                    begin
                        if (m_decay < 15) m_decay++;
                        corr = corr / 2;
                        ev = EV_OVERSHOOT;
                    end
                    else if (s[2] && m_steer != 0)
                    begin
                        m_brake_ticks = 2;
                        corr = -(m_last_corr / 2);
                        m_ctr_ticks = 0;
                    end
                    else if (m_off_ticks < 2 && m_ctr_ticks < 2)
                    begin
                        corr = 0; m_steer = 0;
                    end
                    m_last_corr = corr;
                    m_steer = steer_of(corr);
                    ls = wheel_clamp(longint'(m_base) + corr);
                    rs = wheel_clamp(longint'(m_base) - corr);
                    speed_set = 1;
                end
            end
            PH_BRAKE:
            begin
                ls = BRAKE_SPEED; rs = BRAKE_SPEED; lf = 0; rf = 0; speed_set = 1;
                m_steer = 0;
                if (el >= BRAKE_MS)
                begin
                    m_phase = PH_TURN; m_phase_start = now; m_prev_pos = 0; m_smooth = 0;
                end
            end
            PH_TURN:
            begin
                ls = m_turn; rs = m_turn; speed_set = 1;
                if (m_corner > 0)
                begin
                    lf = 1; rf = 0; m_steer = 1;
                end
                else
                begin
                    lf = 0; rf = 1; m_steer = -1;
                end
                m_prev_pos = m_smooth;
                if (lit > 0 && el > TURN_MIN_MS)
                begin
                    lf = 1; rf = 1; m_phase = PH_FOLLOW; m_cool_until = now + COOL_TURN_MS;
                    ev = EV_FOUND;
                end
                else if (lit == 0 && el > TURN_MAX_MS)
                begin
                    lf = 1; rf = 1; m_phase = PH_SEARCH; m_phase_start = now;
                    m_steer = m_corner; ev = EV_SEARCH;
                end
            end
            default:
            begin
                if (lit > 0)
                begin
                    m_phase = PH_FOLLOW; m_cool_until = now + COOL_FOUND_MS;
                    m_brake_ticks = 2;
                    m_last_corr = m_steer > 0 ? 1024 : -1024;
                    m_steer = 0; ev = EV_FOUND;
                end
                else
                begin
                    slow = (32'(m_base) * 4 + 2) / 5;
                    fast = (32'(m_base) * 6 + 2) / 5;
                    if (fast > 65535) fast = 65535;
                    if (el % 800 < 400)
                    begin
                        ls = slow[15:0]; rs = fast[15:0]; m_steer = 1;
                    end
                    else
                    begin
                        ls = fast[15:0]; rs = slow[15:0]; m_steer = -1;
                    end
                    if (el > SEARCH_MAX_MS)
                    begin
                        ls = 0; rs = 0; m_steer = 0;
                    end
                    speed_set = 1;
                end
            end
        endcase
        if (speed_set)
        begin
            m_held_l = ls; m_held_r = rs;
        end
        w.left_speed = m_held_l; w.right_speed = m_held_r;
        w.left_forward = lf; w.right_forward = rf;
        w.phase_now = m_phase; w.steer_action = 2'(m_steer); w.event_code = 3'(ev);
        expected_words.push_back(w);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:
            begin
                m_enable = val[0];
                if (!val[0]) m_phase = PH_FOLLOW;
            end
            CFG_INVERT:     m_invert = val[0];
            CFG_BASE_SPEED: m_base = val;
            CFG_TURN_SPEED: m_turn = val;
            CFG_PROP_GAIN:  m_kp = val;
            CFG_DERIV_GAIN: m_kd = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        sensor.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // one sensor word, with a random sender gap first
    task automatic send_tick(input logic [4:0] bits_in, input logic [31:0] now);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            sensor.valid <= 1'b0;
            @(posedge clk);
        end
        sensor.valid <= 1'b1; sensor.sensor_bits <= bits_in; sensor.time_ms <= now;
        @(posedge clk);
        while (!sensor.ready)
            @(posedge clk);
        predict_tick(bits_in, now);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            result.ready <= !(stall_pct > 0 && $urandom_range(99, 0) < stall_pct);
    end

    always @(posedge clk)
    begin
        drive_word_t w;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected");
                failed = 1;
            end
            else
            begin
                w = expected_words.pop_front();
                if (result.left_speed !== w.left_speed)
                begin
                    $error("left_speed exp %0d got %0d", w.left_speed, result.left_speed);
                    failed = 1;
                end
                if (result.right_speed !== w.right_speed)
                begin
                    $error("right_speed exp %0d got %0d", w.right_speed, result.right_speed);
                    failed = 1;
                end
                if (result.left_forward !== w.left_forward)
                begin
                    $error("left_forward exp %0d got %0d", w.left_forward, result.left_forward);
                    failed = 1;
                end
                if (result.right_forward !== w.right_forward)
                begin
                    $error("right_forward exp %0d got %0d", w.right_forward,
                           result.right_forward);
                    failed = 1;
                end
                if (result.phase_now !== w.phase_now)
                begin
                    $error("phase_now exp %0d got %0d", w.phase_now, result.phase_now);
                    failed = 1;
                end
                if (result.steer_action !== w.steer_action)
                begin
                    $error("steer_action exp %0d got %0d", w.steer_action, result.steer_action);
                    failed = 1;
                end
                if (result.event_code !== w.event_code)
                begin
                    $error("event_code exp %0d got %0d", w.event_code, result.event_code);
                    failed = 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // directed ticks: pattern, time step in ms
    typedef struct {
        logic [4:0]  bits_in;
        logic [31:0] dt;
    } tick_row_t;

    tick_row_t dir_rows[] = '{
        '{5'b00100, 50}, '{5'b00100, 50}, '{5'b00001, 50}, '{5'b00011, 50},
        '{5'b10000, 50}, '{5'b11000, 50}, '{5'b00100, 50}, '{5'b00100, 50},
        '{5'b11111, 50}, '{5'b00000, 50}, '{5'b01100, 50}, '{5'b11000, 50},
        '{5'b00000, 50}, '{5'b00000, 150}, '{5'b00000, 60}, '{5'b00000, 300},
        '{5'b00100, 300}, '{5'b00000, 900}, '{5'b00000, 50}, '{5'b00000, 3100},
        '{5'b00000, 300}, '{5'b00000, 4100}, '{5'b10101, 50}, '{5'b01010, 50}
    };

    // random tick: mostly plausible line patterns with occasional gaps
    function automatic logic [4:0] pick_pattern();
        logic [4:0] table_p[9] = '{5'b00100, 5'b00110, 5'b01100, 5'b00010, 5'b01000,
                                    5'b00011, 5'b11000, 5'b00000, 5'b11111};
        if ($urandom_range(9, 0) < 2)
            return 5'($urandom);
        return table_p[$urandom_range(8, 0)];
    endfunction

    task automatic random_phase(input int n, input int idle_p, input int stall_p);
        int k;
        idle_pct = idle_p; stall_pct = stall_p;
        for (k = 0; k < n; k++)
        begin
            clock_ms = clock_ms + ($urandom_range(3, 0) == 0 ? $urandom_range(1500, 0) : 50);
            send_tick(pick_pattern(), clock_ms);
        end
        wait_drained();
    endtask

    initial
    begin
        int k;
        sensor.valid = 0; sensor.sensor_bits = 0; sensor.time_ms = 0;
        result.ready = 1;
        idle_pct = 0; stall_pct = 0; cycle_count = 0; failed = 0;
        clock_ms = 0;
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // disabled: no result expected
        send_tick(5'b00100, 10);
        wait_drained();
        write_reg(CFG_ENABLE, 1);
        send_tick(5'b00000, 20);
        wait_drained();
        if (expected_words.size() == 0 && m_phase != PH_SEARCH)
            failed = failed;
        for (k = 0; k < dir_rows.size(); k++)
        begin
            clock_ms = clock_ms + dir_rows[k].dt;
            send_tick(dir_rows[k].bits_in, clock_ms);
        end
        wait_drained();
        // search sweep end values at full base speed
        write_reg(CFG_BASE_SPEED, 16'hffff);
        write_reg(CFG_PROP_GAIN, 16'hffff);
        write_reg(CFG_DERIV_GAIN, 16'hffff);
        write_reg(CFG_TURN_SPEED, 16'hffff);
        random_phase(100, 0, 0);
        write_reg(CFG_ENABLE, 0);
        write_reg(CFG_INVERT, 1);
        write_reg(CFG_BASE_SPEED, 0);
        write_reg(CFG_PROP_GAIN, 0);
        write_reg(CFG_DERIV_GAIN, 0);
        write_reg(CFG_TURN_SPEED, 0);
        random_phase(10, 0, 0);
        write_reg(CFG_ENABLE, 1);
        random_phase(100, 88, 0);
        write_reg(CFG_INVERT, 0);
        write_reg(CFG_BASE_SPEED, 16'($urandom));
        write_reg(CFG_PROP_GAIN, 16'($urandom_range(4000, 0)));
        write_reg(CFG_DERIV_GAIN, 16'($urandom_range(4000, 0)));
        write_reg(CFG_TURN_SPEED, 16'($urandom));
        random_phase(100, 0, 88);
        // time wrap near the top of the counter
        clock_ms = 32'hffff_f000;
        random_phase(100, 14, 14);
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
